>>> design/nfba_pkg.sv
// Shared types and constants for the next-fit block allocator.
// Holds the controller state enum, the command and status structs and the codes.
// No dependencies.
package nfba_pkg;

  localparam int BLK_W = 13;

  localparam logic [1:0] FUNC_RESERVE = 2'd0;
  localparam logic [1:0] FUNC_FREE    = 2'd1;
  localparam logic [1:0] FUNC_WRITE   = 2'd2;
  localparam logic [1:0] FUNC_NOP     = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_FRAG   = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  localparam logic CFG_BLOCK_SIZE  = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  localparam logic [7:0]       RESET_BLOCK_SIZE  = 8'd16;
  localparam logic [BLK_W-1:0] RESET_BLOCK_COUNT = 13'd256;
  localparam logic [7:0]       MAX_DATA_LENGTH   = 8'd255;

  typedef enum logic [4:0] {
    S_CLEAR, S_CLR_END, S_IDLE, S_DISPATCH, S_DIVR, S_RCHK, S_TOP, S_WAIT,
    S_HOP, S_HCHK, S_FREE_HDR, S_DIVF, S_CLRRUN, S_WR_HDR, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR_STEP, OP_CLR_FINISH, OP_LOAD, OP_SET_OK, OP_SET_NOFREE,
    OP_SET_FRAG, OP_SET_RANGE, OP_DIV_START, OP_DIV_STEP, OP_RD_HANDLE,
    OP_SCAN_INIT1, OP_SCAN_INIT2, OP_RD_B, OP_HOP_INIT, OP_ADV, OP_HOP_STEP,
    OP_PLACE, OP_FREE_INIT, OP_FREE_STEP, OP_FREE_END, OP_WR_BYTE, OP_OUT_LOAD
  } op_t;

  typedef enum logic {
    DIV_FROM_LENGTH, DIV_FROM_HEADER
  } div_src_t;

  typedef struct packed {
    op_t      op;
    div_src_t div_src;
  } dp_cmd_t;

  typedef struct packed {
    logic       cfg_wr;
    logic       clr_last;
    logic [1:0] func;
    logic       dl_max;
    logic       hdl_out;
    logic       div_done;
    logic       need_gt_free;
    logic       scan_end;
    logic       pass2;
    logic       rd_nz;
    logic       place_ok;
    logic       hop_last;
    logic       b_ge_nb;
    logic       wr_bad;
    logic       run_done;
    logic       out_free;
  } dp_stat_t;

endpackage

>>> design/nfba_dp.sv
// Datapath of the next-fit block allocator: heap memory, counters and result register.
// Depends on nfba_pkg; driven by commands from nfba_ctrl.
module nfba_dp #(
  parameter int HEAP_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  nfba_pkg::dp_cmd_t             cmd,
  output nfba_pkg::dp_stat_t            stat,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [nfba_pkg::BLK_W-1:0]    cfg_data,
  input  logic [1:0]                    func,
  input  logic [7:0]                    data_length,
  input  logic [11:0]                   handle,
  input  logic [7:0]                    byte_offset,
  input  logic [7:0]                    data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [11:0]                   address,
  output logic [nfba_pkg::BLK_W-1:0]    free_blocks
);
  import nfba_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int LW = $clog2(HEAP_BYTES + 1);
  localparam int CW = ((LW > 13) ? LW : 13) + 1;

  logic [7:0] mem [HEAP_BYTES];
  logic [7:0] rdata;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wd;

  logic [7:0]       bs, bs_eff;
  logic [BLK_W-1:0] bc, nb, free_cnt;
  logic [LW-1:0]    len_bytes;
  logic [CW-1:0]    p, len_c, hdl_c, tgt, bs_c;
  logic [1:0]       fn;
  logic [7:0]       dl, off, dbyte, drem, hrem, jb;
  logic [11:0]      hdl;
  logic [8:0]       dq, blk_left;
  logic [BLK_W-1:0] b, stop, conf, last_b, first_b, first_raw_b, scan_first;
  logic [CW-1:0]    baddr, start_addr, last_addr, first_addr, first_raw_addr, place_addr;
  logic             last_valid, pass2;
  logic [1:0]       res_status;
  logic [CW-1:0]    res_addr;
  logic [BLK_W:0]   free_sum;

  assign bs_eff = (bs == 8'd0) ? 8'd1 : bs;
  assign bs_c   = CW'(bs_eff);
  assign len_c  = CW'(len_bytes);
  assign hdl_c  = CW'(hdl);
  assign tgt    = hdl_c + CW'(1) + CW'(off);
  assign place_addr = (conf == '0) ? baddr : start_addr;
  assign free_sum   = (BLK_W+1)'(free_cnt) + (BLK_W+1)'(dq);

  always_comb begin
    first_raw_b    = last_valid ? last_b + BLK_W'(1) : '0;
    first_raw_addr = last_valid ? last_addr + bs_c : '0;
    if (first_raw_b >= nb) begin
      first_b    = '0;
      first_addr = '0;
    end else begin
      first_b    = first_raw_b;
      first_addr = first_raw_addr;
    end
  end

  always_comb begin
    mem_we   = 1'b0;
    mem_addr = '0;
    mem_wd   = '0;
    unique case (cmd.op)
      OP_CLR_STEP, OP_FREE_STEP: begin
        mem_we   = 1'b1;
        mem_addr = p[AW-1:0];
      end
      OP_RD_HANDLE: mem_addr = hdl_c[AW-1:0];
      OP_RD_B:      mem_addr = baddr[AW-1:0];
      OP_PLACE: begin
        mem_we   = 1'b1;
        mem_addr = place_addr[AW-1:0];
        mem_wd   = dl + 8'd1;
      end
      OP_WR_BYTE: begin
        mem_we   = 1'b1;
        mem_addr = tgt[AW-1:0];
        mem_wd   = dbyte;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bs         <= RESET_BLOCK_SIZE;
      bc         <= RESET_BLOCK_COUNT;
      p          <= '0;
      nb         <= '0;
      len_bytes  <= '0;
      free_cnt   <= '0;
      last_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && cmd.op != OP_OUT_LOAD) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_BLOCK_SIZE) begin
          bs <= cfg_data[7:0];
        end else begin
          bc <= cfg_data;
        end
        p         <= '0;
        nb        <= '0;
        len_bytes <= '0;
      end else begin
        unique case (cmd.op)
          OP_CLR_STEP: begin
            p <= p + CW'(1);
            if (nb < bc && CW'(len_bytes) + bs_c <= CW'(HEAP_BYTES)) begin
              nb        <= nb + BLK_W'(1);
              len_bytes <= len_bytes + LW'(bs_eff);
            end
          end
          OP_CLR_FINISH: begin
            free_cnt   <= nb;
            last_valid <= 1'b0;
          end
          OP_LOAD: begin
            fn    <= func;
            dl    <= data_length;
            hdl   <= handle;
            off   <= byte_offset;
            dbyte <= data_byte;
          end
          OP_SET_OK:     begin res_status <= ST_OK;     res_addr <= '0; end
          OP_SET_NOFREE: begin res_status <= ST_NOFREE; res_addr <= '0; end
          OP_SET_FRAG:   begin res_status <= ST_FRAG;   res_addr <= '0; end
          OP_SET_RANGE:  begin res_status <= ST_RANGE;  res_addr <= '0; end
          OP_DIV_START: begin
            drem <= (cmd.div_src == DIV_FROM_HEADER) ? rdata - 8'd1 : dl;
            dq   <= 9'd1;
          end
          OP_DIV_STEP: begin
            if (drem >= bs_eff) begin
              drem <= drem - bs_eff;
              dq   <= dq + 9'd1;
            end
          end
          OP_SCAN_INIT1: begin
            b          <= first_b;
            baddr      <= first_addr;
            stop       <= nb;
            conf       <= '0;
            pass2      <= 1'b0;
            scan_first <= first_b;
          end
          OP_SCAN_INIT2: begin
            b     <= '0;
            baddr <= '0;
            stop  <= scan_first;
            conf  <= '0;
            pass2 <= 1'b1;
          end
          OP_HOP_INIT: begin
            conf <= '0;
            hrem <= rdata;
          end
          OP_ADV: begin
            if (conf == '0) begin
              start_addr <= baddr;
            end
            conf  <= conf + BLK_W'(1);
            b     <= b + BLK_W'(1);
            baddr <= baddr + bs_c;
          end
          OP_HOP_STEP: begin
            b     <= b + BLK_W'(1);
            baddr <= baddr + bs_c;
            hrem  <= hrem - bs_eff;
          end
          OP_PLACE: begin
            last_b     <= b;
            last_addr  <= baddr;
            last_valid <= 1'b1;
            free_cnt   <= free_cnt - BLK_W'(dq);
            res_status <= ST_OK;
            res_addr   <= place_addr;
          end
          OP_FREE_INIT: begin
            p        <= hdl_c;
            jb       <= '0;
            blk_left <= dq;
          end
          OP_FREE_STEP: begin
            p <= p + CW'(1);
            if (jb == bs_eff - 8'd1) begin
              jb       <= '0;
              blk_left <= blk_left - 9'd1;
            end else begin
              jb <= jb + 8'd1;
            end
          end
          OP_FREE_END: begin
            free_cnt   <= (free_sum > (BLK_W+1)'(nb)) ? nb : free_sum[BLK_W-1:0];
            res_status <= ST_OK;
            res_addr   <= '0;
          end
          OP_WR_BYTE: begin
            res_status <= ST_OK;
            res_addr   <= '0;
          end
          OP_OUT_LOAD: begin
            out_valid   <= 1'b1;
            status      <= res_status;
            address     <= res_addr[11:0];
            free_blocks <= free_cnt;
          end
          default: ;
        endcase
      end
    end
  end

  // The first pass of a scan keeps its start block in scan_first, so the
  // wrap-around pass can stop there without disturbing the next-fit position.
  always_comb begin
    stat.cfg_wr       = cfg_we;
    stat.clr_last     = (p == CW'(HEAP_BYTES - 1));
    stat.func         = fn;
    stat.dl_max       = (dl == MAX_DATA_LENGTH);
    stat.hdl_out      = (hdl_c >= len_c);
    stat.div_done     = (drem < bs_eff);
    stat.need_gt_free = ((BLK_W)'(dq) > free_cnt);
    stat.scan_end     = !((b < stop) && (b < nb));
    stat.pass2        = pass2;
    stat.rd_nz        = (rdata != 8'd0);
    stat.place_ok     = ((BLK_W+1)'(conf) + (BLK_W+1)'(1) >= (BLK_W+1)'(dq));
    stat.hop_last     = (hrem <= bs_eff);
    stat.b_ge_nb      = (b >= nb);
    stat.wr_bad       = (rdata == 8'd0) || ({1'b0, off} + 9'd1 >= {1'b0, rdata})
                        || (tgt >= len_c);
    stat.run_done     = (blk_left == 9'd0) || (p >= len_c);
    stat.out_free     = !out_valid || out_ready;
  end

endmodule

>>> design/nfba_ctrl.sv
// Controller state machine of the next-fit block allocator.
// Depends on nfba_pkg; issues one command per cycle to nfba_dp.
module nfba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  nfba_pkg::dp_stat_t stat,
  output nfba_pkg::dp_cmd_t  cmd
);
  import nfba_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (stat.clr_last) state_next = S_CLR_END;
      S_CLR_END: state_next = S_IDLE;
      S_IDLE:    if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        unique case (stat.func)
          FUNC_RESERVE: state_next = stat.dl_max ? S_DONE : S_DIVR;
          FUNC_FREE:    state_next = stat.hdl_out ? S_DONE : S_FREE_HDR;
          FUNC_WRITE:   state_next = stat.hdl_out ? S_DONE : S_WR_HDR;
          default:      state_next = S_DONE;
        endcase
      end
      S_DIVR:    if (stat.div_done) state_next = S_RCHK;
      S_RCHK:    state_next = stat.need_gt_free ? S_DONE : S_TOP;
      S_TOP:     if (stat.scan_end) begin
                   state_next = stat.pass2 ? S_DONE : S_TOP;
                 end else begin
                   state_next = S_WAIT;
                 end
      S_WAIT: begin
        priority if (stat.rd_nz) state_next = S_HOP;
        else if (stat.place_ok)  state_next = S_DONE;
        else                     state_next = S_TOP;
      end
      S_HOP:     if (stat.hop_last) state_next = S_HCHK;
      S_HCHK: begin
        if (stat.b_ge_nb) begin
          state_next = stat.pass2 ? S_DONE : S_TOP;
        end else begin
          state_next = S_WAIT;
        end
      end
      S_FREE_HDR: state_next = stat.rd_nz ? S_DIVF : S_DONE;
      S_DIVF:     if (stat.div_done) state_next = S_CLRRUN;
      S_CLRRUN:   if (stat.run_done) state_next = S_DONE;
      S_WR_HDR:   state_next = S_DONE;
      S_DONE:     if (stat.out_free) state_next = S_IDLE;
      default:    state_next = S_CLEAR;
    endcase
    if (stat.cfg_wr) begin
      state_next = S_CLEAR;
    end
  end

  always_comb begin
    cmd.op      = OP_NONE;
    cmd.div_src = DIV_FROM_LENGTH;
    in_ready    = (state == S_IDLE);
    unique case (state)
      S_CLEAR:   cmd.op = OP_CLR_STEP;
      S_CLR_END: cmd.op = OP_CLR_FINISH;
      S_IDLE:    if (in_valid) cmd.op = OP_LOAD;
      S_DISPATCH: begin
        unique case (stat.func)
          FUNC_RESERVE: cmd.op = stat.dl_max ? OP_SET_FRAG : OP_DIV_START;
          FUNC_FREE:    cmd.op = stat.hdl_out ? OP_SET_OK : OP_RD_HANDLE;
          FUNC_WRITE:   cmd.op = stat.hdl_out ? OP_SET_RANGE : OP_RD_HANDLE;
          default:      cmd.op = OP_SET_OK;
        endcase
      end
      S_DIVR:    if (!stat.div_done) cmd.op = OP_DIV_STEP;
      S_DIVF:    cmd.op = stat.div_done ? OP_FREE_INIT : OP_DIV_STEP;
      S_RCHK:    cmd.op = stat.need_gt_free ? OP_SET_NOFREE : OP_SCAN_INIT1;
      S_TOP: begin
        if (stat.scan_end) begin
          cmd.op = stat.pass2 ? OP_SET_FRAG : OP_SCAN_INIT2;
        end else begin
          cmd.op = OP_RD_B;
        end
      end
      S_WAIT: begin
        priority if (stat.rd_nz) cmd.op = OP_HOP_INIT;
        else if (stat.place_ok)  cmd.op = OP_PLACE;
        else                     cmd.op = OP_ADV;
      end
      S_HOP:     cmd.op = OP_HOP_STEP;
      S_HCHK: begin
        if (stat.b_ge_nb) begin
          cmd.op = stat.pass2 ? OP_SET_FRAG : OP_SCAN_INIT2;
        end else begin
          cmd.op = OP_RD_B;
        end
      end
      S_FREE_HDR: begin
        cmd.op      = stat.rd_nz ? OP_DIV_START : OP_SET_OK;
        cmd.div_src = DIV_FROM_HEADER;
      end
      S_CLRRUN:  cmd.op = stat.run_done ? OP_FREE_END : OP_FREE_STEP;
      S_WR_HDR:  cmd.op = stat.wr_bad ? OP_SET_RANGE : OP_WR_BYTE;
      S_DONE:    if (stat.out_free) cmd.op = OP_OUT_LOAD;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

>>> design/next_fit_block_allocator_unit.sv
// Top level of the next-fit block allocator.
// Depends on nfba_pkg, nfba_ctrl and nfba_dp.
//
// Usage: a request is one transfer on the input channel (in_valid/in_ready) carrying func,
// data_length, handle, byte_offset and data_byte. Each request yields exactly one transfer
// on the output channel (out_valid/out_ready) with status, address and free_blocks.
// One request is worked on at a time. A reserve first divides the length by the block size
// by repeated subtraction, then walks block headers through the single heap memory port,
// stepping block by block over each allocated run, up to block_count blocks per pass. A free
// reads the header, divides, then clears one byte per cycle over the run.
// The result sits in an output register, so the next request is accepted as soon as the
// controller is back in idle even while the receiver stalls; the following result then
// waits until the register is taken.
// Reset, and any configuration write, starts a clearing pass that
// zeroes the heap one byte per cycle and works out the usable block count; no request is
// accepted during it. Configuration writes (cfg_we, cfg_index, cfg_data) take effect at
// once and must only be issued while the block is idle.
module next_fit_block_allocator_unit #(
  parameter int HEAP_BYTES = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [nfba_pkg::BLK_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 func,
  input  logic [7:0]                 data_length,
  input  logic [11:0]                handle,
  input  logic [7:0]                 byte_offset,
  input  logic [7:0]                 data_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic [11:0]                address,
  output logic [nfba_pkg::BLK_W-1:0] free_blocks
);
  import nfba_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences every request; the datapath owns all storage.
  nfba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nfba_dp #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .func        (func),
    .data_length (data_length),
    .handle      (handle),
    .byte_offset (byte_offset),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .address     (address),
    .free_blocks (free_blocks)
  );

endmodule

>>> design/nfba_checker.sv
// Port-level checker for the next-fit block allocator, bound to the top level.
// Depends on nfba_pkg and next_fit_block_allocator_unit.
module nfba_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       cfg_we,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 status,
  input logic [11:0]                address,
  input logic [nfba_pkg::BLK_W-1:0] free_blocks
);
  import nfba_pkg::*;

  // Reset starts the clearing pass, so no request is taken just after it.
  a_reset_clears: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("request accepted right after reset");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst) cfg_we |=> !in_ready)
    else $error("request accepted right after a configuration write");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while one is in work");

  a_addr_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK) || (address == 12'd0))
    else $error("address given with a failing status");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(address)
      && $stable(free_blocks))
    else $error("stalled result changed");

endmodule

bind next_fit_block_allocator_unit nfba_checker u_nfba_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_we      (cfg_we),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .address     (address),
  .free_blocks (free_blocks)
);
